@@ rtl/buddy_page_allocator_defines.svh @@
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpa assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpa assertion failed");

`endif

@@ rtl/bpa_pkg.sv @@
// constants, types and helper functions for the buddy page allocator
package bpa_pkg;

    localparam int MIN_BLOCK_ORDER = 12;
    localparam int MAX_BLOCK_ORDER = 20;
    localparam int NUM_ORDERS      = MAX_BLOCK_ORDER - MIN_BLOCK_ORDER + 1;
    localparam int PAGE_W          = MAX_BLOCK_ORDER - MIN_BLOCK_ORDER;
    localparam int NUM_PAGES       = 1 << PAGE_W;
    localparam int LINK_W          = PAGE_W + 1;
    localparam int ORD_W           = $clog2(NUM_ORDERS);
    localparam int META_W          = ORD_W + 1;
    localparam int SIZE_W          = 22;
    localparam int OFFS_W          = 20;

    localparam logic [ORD_W-1:0]  TOP_ORD  = ORD_W'(NUM_ORDERS - 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_PAGES);

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ORD_W-1:0]  ord_t;

    typedef struct packed {
        logic free;
        ord_t ord;
    } meta_t;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_SRCH = 14'b00000000000010,
        S_ARD  = 14'b00000000000100,
        S_AUL  = 14'b00000000001000,
        S_SPL  = 14'b00000000010000,
        S_FRD  = 14'b00000000100000,
        S_FUL  = 14'b00000001000000,
        S_MRD  = 14'b00000010000000,
        S_MCK  = 14'b00000100000000,
        S_PRD  = 14'b00001000000000,
        S_PUL  = 14'b00010000000000,
        S_PW1  = 14'b00100000000000,
        S_PW2  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } state_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    function automatic logic size_bad(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] lim;
        lim = SIZE_W'(64'd1 << MAX_BLOCK_ORDER);
        size_bad = size[SIZE_W-1] || (size > lim);
    endfunction

    function automatic ord_t size_order(input logic [SIZE_W-1:0] size);
        ord_t r;
        logic [SIZE_W:0] blk;
        r = TOP_ORD;
        for (int i = NUM_ORDERS - 1; i >= 0; i--)
        begin
            blk = (SIZE_W+1)'(64'd1 << (i + MIN_BLOCK_ORDER));
            if (blk >= {1'b0, size})
            begin
                r = ORD_W'(i);
            end
        end
        size_order = r;
    endfunction

    function automatic page_t page_bit(input ord_t o);
        page_t r;
        r = '0;
        for (int i = 0; i < PAGE_W; i++)
        begin
            if (o == ORD_W'(i))
            begin
                r[i] = 1'b1;
            end
        end
        page_bit = r;
    endfunction

    function automatic ord_t clamp_ord(input ord_t o);
        clamp_ord = (o > TOP_ORD) ? TOP_ORD : o;
    endfunction

endpackage

@@ rtl/buddy_page_allocator.sv @@
// buddy page allocator top level: sequencer, list heads and link/meta memories
// alloc: search upward by order, unlink the block, split and push each buddy, output
// free: unlink the page if free, merge buddies upward, push the final block, output
// one request in flight; each step waits on the registered memory read
// reset clears control state; the top order list holds page 0, whose links read as null
module buddy_page_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_bytes[21:0], block_offset[41:22], zero
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_offset[19:0], zero
    output logic        m_tuser    // success
);
    import bpa_pkg::*;

    state_t state_reg, state_next;
    logic   op_reg, op_next;
    ord_t   req_reg, req_next;
    ord_t   cur_reg, cur_next;
    page_t  page_reg, page_next;
    page_t  tgt_reg, tgt_next;
    ord_t   pord_reg, pord_next;
    link_t  h_reg, h_next;
    logic   ok_reg, ok_next;
    logic [OFFS_W-1:0] res_reg, res_next;
    link_t  head_reg [NUM_ORDERS];

    logic              out_valid_reg;
    logic [OFFS_W-1:0] out_offs_reg;
    logic              out_ok_reg;

    logic   next_we, prev_we, meta_we;
    page_t  next_wa, prev_wa, meta_wa, raddr;
    link_t  next_wd, prev_wd, next_q, prev_q;
    link_t  next_rd, prev_rd;
    meta_t  meta_wd, meta_q, meta_rd;
    logic [NUM_PAGES-1:0] valid_reg;
    logic   mv_reg;
    page_t  ma_reg;

    logic   head_we;
    ord_t   head_wa;
    link_t  head_wd;

    logic   ul_en;
    page_t  ul_page;
    ord_t   ul_ord;
    ord_t   rd_ord;
    link_t  cur_head;
    logic   merge_ok;
    page_t  merged;
    ord_t   cur_inc;

    logic [SIZE_W-1:0] in_size;
    logic [OFFS_W-1:0] in_offs;

    assign in_size = s_tdata[SIZE_W-1:0];
    assign in_offs = s_tdata[SIZE_W+OFFS_W-1:SIZE_W];

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(raddr), .rdata(next_q)
    );

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(raddr), .rdata(prev_q)
    );

    bpa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
        .raddr(raddr), .rdata(meta_q)
    );

    // unwritten meta entries read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mv_reg    <= 1'b0;
            ma_reg    <= '0;
        end
        else
        begin
            if (meta_we)
            begin
                valid_reg[meta_wa] <= 1'b1;
            end
            mv_reg <= valid_reg[raddr];
            ma_reg <= raddr;
        end
    end

    always_comb
    begin
        if (mv_reg)
        begin
            meta_rd = meta_q;
        end
        else if (ma_reg == '0)
        begin
            meta_rd = '{free: 1'b1, ord: TOP_ORD};
        end
        else
        begin
            meta_rd = '0;
        end
    end

    // page 0 links are null until its first meta write
    assign next_rd = (!mv_reg && ma_reg == '0) ? NIL_LINK : next_q;
    assign prev_rd = (!mv_reg && ma_reg == '0) ? NIL_LINK : prev_q;

    assign rd_ord   = clamp_ord(meta_rd.ord);
    assign cur_head = head_reg[cur_reg];
    assign merge_ok = meta_rd.free && (meta_rd.ord == cur_reg);
    assign merged   = page_reg & ~page_bit(cur_reg);
    assign cur_inc  = cur_reg + ord_t'(1);

    always_comb
    begin
        case (state_reg)
            S_MRD:   raddr = tgt_reg;
            S_PRD:   raddr = tgt_reg;
            default: raddr = page_reg;
        endcase
    end

    // unlink of the page just read, and the push writes
    always_comb
    begin
        ul_en   = 1'b0;
        ul_page = page_reg;
        ul_ord  = meta_rd.ord;
        case (state_reg)
            S_AUL:
            begin
                ul_en  = 1'b1;
                ul_ord = req_reg;
            end
            S_FUL:   ul_en = meta_rd.free;
            S_MCK:
            begin
                ul_en   = merge_ok;
                ul_page = tgt_reg;
            end
            S_PUL:
            begin
                ul_en   = meta_rd.free;
                ul_page = tgt_reg;
            end
            default: ul_en = 1'b0;
        endcase

        next_we = 1'b0;
        next_wa = prev_rd[PAGE_W-1:0];
        next_wd = next_rd;
        prev_we = 1'b0;
        prev_wa = next_rd[PAGE_W-1:0];
        prev_wd = prev_rd;
        meta_we = 1'b0;
        meta_wa = ul_page;
        meta_wd = '{free: 1'b0, ord: ul_ord};
        head_we = 1'b0;
        head_wa = rd_ord;
        head_wd = next_rd;

        if (ul_en)
        begin
            meta_we = 1'b1;
            prev_we = !next_rd[PAGE_W];
            if (!prev_rd[PAGE_W])
            begin
                next_we = 1'b1;
            end
            else
            begin
                head_we = 1'b1;
            end
        end

        case (state_reg)
            S_PW1:
            begin
                meta_we = 1'b1;
                meta_wa = tgt_reg;
                meta_wd = '{free: 1'b1, ord: pord_reg};
                prev_we = 1'b1;
                prev_wa = tgt_reg;
                prev_wd = NIL_LINK;
                next_we = 1'b1;
                next_wa = tgt_reg;
                next_wd = head_reg[pord_reg];
                head_we = 1'b1;
                head_wa = pord_reg;
                head_wd = {1'b0, tgt_reg};
            end
            S_PW2:
            begin
                prev_we = !h_reg[PAGE_W];
                prev_wa = h_reg[PAGE_W-1:0];
                prev_wd = {1'b0, tgt_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i] <= (i == NUM_ORDERS - 1) ? '0 : NIL_LINK;
            end
        end
        else if (head_we)
        begin
            head_reg[head_wa] <= head_wd;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        req_next   = req_reg;
        cur_next   = cur_reg;
        page_next  = page_reg;
        tgt_next   = tgt_reg;
        pord_next  = pord_reg;
        h_next     = h_reg;
        ok_next    = ok_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next = s_tuser;
                    ok_next  = 1'b0;
                    res_next = '0;
                    if (s_tuser == OP_FREE)
                    begin
                        page_next  = in_offs[OFFS_W-1:MIN_BLOCK_ORDER];
                        state_next = S_FRD;
                    end
                    else if (size_bad(in_size))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        req_next   = size_order(in_size);
                        cur_next   = size_order(in_size);
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (!cur_head[PAGE_W])
                begin
                    page_next  = cur_head[PAGE_W-1:0];
                    state_next = S_ARD;
                end
                else if (cur_reg == TOP_ORD)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next = cur_inc;
                end
            end
            S_ARD:   state_next = S_AUL;
            S_AUL:   state_next = S_SPL;
            S_SPL:
            begin
                if (cur_reg > req_reg)
                begin
                    cur_next   = cur_reg - ord_t'(1);
                    tgt_next   = page_reg ^ page_bit(cur_reg - ord_t'(1));
                    pord_next  = cur_reg - ord_t'(1);
                    state_next = S_PRD;
                end
                else
                begin
                    ok_next    = 1'b1;
                    res_next   = {page_reg, {MIN_BLOCK_ORDER{1'b0}}};
                    state_next = S_DONE;
                end
            end
            S_FRD:   state_next = S_FUL;
            S_FUL:
            begin
                cur_next = rd_ord;
                if (rd_ord == TOP_ORD)
                begin
                    tgt_next   = page_reg;
                    pord_next  = rd_ord;
                    state_next = S_PRD;
                end
                else
                begin
                    tgt_next   = page_reg ^ page_bit(rd_ord);
                    state_next = S_MRD;
                end
            end
            S_MRD:   state_next = S_MCK;
            S_MCK:
            begin
                if (merge_ok)
                begin
                    page_next = merged;
                    cur_next  = cur_inc;
                    if (cur_inc == TOP_ORD)
                    begin
                        tgt_next   = merged;
                        pord_next  = cur_inc;
                        state_next = S_PRD;
                    end
                    else
                    begin
                        tgt_next   = merged ^ page_bit(cur_inc);
                        state_next = S_MRD;
                    end
                end
                else
                begin
                    tgt_next   = page_reg;
                    pord_next  = cur_reg;
                    state_next = S_PRD;
                end
            end
            S_PRD:   state_next = S_PUL;
            S_PUL:   state_next = S_PW1;
            S_PW1:
            begin
                h_next     = head_reg[pord_reg];
                state_next = S_PW2;
            end
            S_PW2:
            begin
                if (op_reg == OP_FREE)
                begin
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SPL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        req_reg  <= req_next;
        cur_reg  <= cur_next;
        page_reg <= page_next;
        tgt_reg  <= tgt_next;
        pord_reg <= pord_next;
        h_reg    <= h_next;
        ok_reg   <= ok_next;
        res_reg  <= res_next;
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
        begin
            out_offs_reg <= res_reg;
            out_ok_reg   <= ok_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_offs_reg};
    assign m_tuser  = out_ok_reg;

endmodule

@@ rtl/bpa_ram.sv @@
// generic simple dual-port ram with registered read
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bpa_checker.sv @@
// port-level checker for the buddy page allocator, bound to the top level
`include "buddy_page_allocator_defines.svh"

module bpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    `BPA_ASSERT_NOW(a_fail_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == 24'd0)
    `BPA_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[23:20] == 4'd0)
    `BPA_ASSERT_NOW(a_page_align, clk, rst_n, m_tvalid, m_tdata[11:0] == 12'd0)
    `BPA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk(clk), .rst_n(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ dv/tb_buddy_page_allocator.sv @@
// testbench for the buddy page allocator: directed table and random requests checked by a predictor
`timescale 1ns / 1ps
module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int NIL = NUM_PAGES;

    typedef struct {
        logic        op;
        int          bytes;
        int          offs;
        logic        known;
        logic [19:0] exp_offs;
        logic        exp_ok;
    } req_row_t;

    typedef struct {
        logic [19:0] offs;
        logic        ok;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;

    int     heads [NUM_ORDERS];
    int     nxt [NUM_PAGES];
    int     prv [NUM_PAGES];
    int     pord [NUM_PAGES];
    bit     phead [NUM_PAGES];
    grant_t grants_pending [$];
    int     errors;
    int     live_blocks [$];
    bit     calm;

    buddy_page_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void list_unlink(input int p);
        int o;
        o = pord[p] >= NUM_ORDERS ? NUM_ORDERS - 1 : pord[p];
        if (prv[p] < NIL)
            nxt[prv[p]] = nxt[p];
        else
            heads[o] = nxt[p];
        if (nxt[p] < NIL)
            prv[nxt[p]] = prv[p];
        phead[p] = 0;
    endfunction

    function automatic void list_push(input int p, input int o);
        if (phead[p])
            list_unlink(p);
        pord[p] = o;
        prv[p] = NIL;
        nxt[p] = heads[o];
        if (heads[o] < NIL)
            prv[heads[o]] = p;
        heads[o] = p;
        phead[p] = 1;
    endfunction

    function automatic void allocator_reset();
        for (int i = 0; i < NUM_ORDERS; i++)
            heads[i] = NIL;
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            nxt[i] = 0;
            prv[i] = 0;
            pord[i] = 0;
            phead[i] = 0;
        end
        list_push(0, NUM_ORDERS - 1);
    endfunction

    function automatic grant_t allocator_step(input logic op, input int bytes, input int offs);
        grant_t g;
        int req;
        int p;
        int c;
        int b;
        g.offs = '0;
        g.ok = 1'b0;
        if (op == OP_ALLOC)
        begin
            if (bytes < 0 || bytes > (1 << MAX_BLOCK_ORDER))
                return g;
            req = 0;
            while (req < NUM_ORDERS - 1 && (1 << (req + MIN_BLOCK_ORDER)) < bytes)
                req++;
            for (c = req; c < NUM_ORDERS; c++)
            begin
                p = heads[c];
                if (p < NIL)
                begin
                    list_unlink(p);
                    pord[p] = req;
                    while (c > req)
                    begin
                        c--;
                        list_push(p ^ (1 << c), c);
                    end
                    g.offs = 20'(p << MIN_BLOCK_ORDER);
                    g.ok = 1'b1;
                    return g;
                end
            end
            return g;
        end
        p = (offs >> MIN_BLOCK_ORDER) & (NUM_PAGES - 1);
        c = pord[p] >= NUM_ORDERS ? NUM_ORDERS - 1 : pord[p];
        if (phead[p])
            list_unlink(p);
        while (c < NUM_ORDERS - 1)
        begin
            b = p ^ (1 << c);
            if (!(phead[b] && pord[b] == c))
                break;
            list_unlink(b);
            p &= ~(1 << c);
            c++;
        end
        list_push(p, c);
        g.ok = 1'b1;
        return g;
    endfunction

    task automatic send_request(input req_row_t r);
        grant_t g;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {6'b0, 20'(r.offs), 22'(r.bytes)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = allocator_step(r.op, r.bytes, r.offs);
        if (r.known && (g.offs != r.exp_offs || g.ok != r.exp_ok))
            report("table row", g.offs, r.exp_offs);
        if (r.op == OP_ALLOC && g.ok)
            live_blocks.push_back(g.offs);
        grants_pending.push_back(g);
    endtask

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (grants_pending.size() == 0)
                    report("unexpected result", m_tdata[19:0], -1);
                else
                begin
                    if (m_tdata[19:0] != grants_pending[0].offs)
                        report("result_offset", m_tdata[19:0], grants_pending[0].offs);
                    if (m_tuser != grants_pending[0].ok)
                        report("success", m_tuser, grants_pending[0].ok);
                    void'(grants_pending.pop_front());
                end
            end
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #40ms;
        $display("buddy_page_allocator verification failed");
        $finish;
    end

    initial
    begin
        req_row_t table_rows [$];
        req_row_t r;
        int k;
        int wait_cycles;
        errors = 0;
        calm = 0;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_ALLOC;
        allocator_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // op, bytes, offset, known, offset out, ok
        table_rows = '{
            '{OP_ALLOC, -1, 0, 1, 20'd0, 1'b0},
            '{OP_ALLOC, 1048577, 0, 1, 20'd0, 1'b0},
            '{OP_ALLOC, -2097152, 0, 1, 20'd0, 1'b0},
            '{OP_ALLOC, 2097151, 0, 1, 20'd0, 1'b0},
            '{OP_ALLOC, 0, 0, 1, 20'd0, 1'b1},
            '{OP_ALLOC, 1, 0, 1, 20'h01000, 1'b1},
            '{OP_ALLOC, 4097, 0, 0, 0, 0},
            '{OP_ALLOC, 1048576, 0, 1, 20'd0, 1'b0},
            '{OP_FREE, 0, 20'h00fff, 0, 0, 0},
            '{OP_FREE, 0, 20'h01000, 0, 0, 0},
            '{OP_FREE, 0, 20'h02000, 0, 0, 0},
            '{OP_ALLOC, 1048576, 0, 1, 20'd0, 1'b1},
            '{OP_ALLOC, 4096, 0, 1, 20'd0, 1'b0},
            '{OP_FREE, 0, 20'hfffff, 0, 0, 0},
            '{OP_FREE, 0, 0, 0, 0, 0},
            '{OP_FREE, 0, 0, 0, 0, 0},
            '{OP_ALLOC, 524288, 0, 0, 0, 0},
            '{OP_ALLOC, 524289, 0, 0, 0, 0},
            '{OP_FREE, 0, 20'h80000, 0, 0, 0},
            '{OP_ALLOC, 8192, 0, 0, 0, 0},
            '{OP_FREE, 0, 20'h55555, 0, 0, 0},
            '{OP_FREE, 0, 20'haaaaa, 0, 0, 0}
        };
        foreach (table_rows[i])
            send_request(table_rows[i]);

        for (int n = 0; n < 1900; n++)
        begin
            if (n > 1700)
                calm = 1;
            r.known = 0;
            r.bytes = 0;
            r.offs = 0;
            k = $urandom_range(0, 99);
            if (k < 50 || live_blocks.size() == 0 && k < 85)
            begin
                r.op = OP_ALLOC;
                case ($urandom_range(0, 9))
                    0: r.bytes = int'($urandom_range(0, 22'h3fffff)) - (1 << 21);
                    1: r.bytes = $urandom_range(0, 1 << 20);
                    2, 3: r.bytes = 1 << $urandom_range(12, 20);
                    default: r.bytes = $urandom_range(0, 1 << $urandom_range(12, 17));
                endcase
            end
            else
            begin
                r.op = OP_FREE;
                if (live_blocks.size() > 0 && k < 92)
                begin
                    k = $urandom_range(0, live_blocks.size() - 1);
                    r.offs = live_blocks[k] | $urandom_range(0, 4095);
                    live_blocks.delete(k);
                end
                else
                    r.offs = $urandom_range(0, 20'hfffff);
                r.bytes = int'($urandom_range(0, 22'h3fffff)) - (1 << 21);
            end
            send_request(r);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (grants_pending.size() > 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (80) @(posedge clk);
        if (errors == 0 && grants_pending.size() == 0)
            $display("buddy_page_allocator verification clean");
        else
            $display("buddy_page_allocator verification failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator.sv
rtl/bpa_checker.sv
dv/tb_buddy_page_allocator.sv
